// ===== rtl/core/acc_pkg.sv =====
// Shared types and constants for the alarm clock calendar.
// No dependencies; every file of the block but the two channel interfaces refers to this package by scoped names.
`timescale 1ns / 1ps

package acc_pkg;

   localparam logic [11:0] YearFirst = 12'd2000;
   localparam logic [11:0] YearLast  = 12'd2099;
   localparam logic [5:0]  SecPerMin = 6'd60;
   localparam logic [5:0]  MinuteMax = 6'd59;
   localparam logic [3:0]  HourNoon  = 4'd12;
   localparam logic [3:0]  HourWrap  = 4'd13;
   localparam logic [3:0]  MonthWrap = 4'd13;

   typedef enum logic [1:0] {
      REQ_TICK    = 2'd0,
      REQ_BUTTONS = 2'd1,
      REQ_TEMP    = 2'd2,
      REQ_NONE    = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      MODE_TIME  = 2'd0,
      MODE_DATE  = 2'd1,
      MODE_ALARM = 2'd2,
      MODE_TEMP  = 2'd3
   } mode_type;

   typedef struct packed {
      logic [5:0]  seconds;
      logic [5:0]  minutes;
      logic [3:0]  hours;
      logic        pm_flag;
      logic [4:0]  day_of_month;
      logic [3:0]  month_num;
      logic [11:0] year_num;
      mode_type    display_mode;
      logic [3:0]  alarm_hour;
      logic [5:0]  alarm_minute;
      logic        alarm_pm;
      logic [1:0]  alarm_phase;
      logic [7:0]  temperature;
   } state_type;

   localparam state_type StateReset = '{
      seconds:      6'd0,
      minutes:      6'd0,
      hours:        4'd12,
      pm_flag:      1'b0,
      day_of_month: 5'd1,
      month_num:    4'd1,
      year_num:     12'd2000,
      display_mode: MODE_TIME,
      alarm_hour:   4'd12,
      alarm_minute: 6'd0,
      alarm_pm:     1'b0,
      alarm_phase:  2'd0,
      temperature:  8'd69
   };

   typedef struct packed {
      logic [3:0] digit_0;
      logic [3:0] digit_1;
      logic [3:0] digit_2;
      logic [3:0] digit_3;
      logic [3:0] digit_4;
      logic [3:0] digit_5;
      logic       pm_lamp;
      logic       alarm_active;
      logic [1:0] mode_now;
   } rsp_data_type;

endpackage

// ===== rtl/core/acc_req_if.sv =====
// Request channel of the alarm clock calendar: valid/ready plus the item fields.
// No dependencies.
`timescale 1ns / 1ps

interface acc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [2:0] button_mask;
   logic [7:0] temp_value;

   modport source (output valid, req_type, button_mask, temp_value, input ready);
   modport sink (input valid, req_type, button_mask, temp_value, output ready);
endinterface

// ===== rtl/core/acc_rsp_if.sv =====
// Result channel of the alarm clock calendar: valid/ready plus the display fields.
// No dependencies.
`timescale 1ns / 1ps

interface acc_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] digit_0;
   logic [3:0] digit_1;
   logic [3:0] digit_2;
   logic [3:0] digit_3;
   logic [3:0] digit_4;
   logic [3:0] digit_5;
   logic       pm_lamp;
   logic       alarm_active;
   logic [1:0] mode_now;

   modport source (output valid, digit_0, digit_1, digit_2, digit_3, digit_4, digit_5,
                   pm_lamp, alarm_active, mode_now, input ready);
   modport sink (input valid, digit_0, digit_1, digit_2, digit_3, digit_4, digit_5,
                 pm_lamp, alarm_active, mode_now, output ready);
endinterface

// ===== rtl/core/acc_core.sv =====
// Clock, calendar and alarm state with its next-state logic for one item.
// Depends on acc_pkg.
`timescale 1ns / 1ps

module acc_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic [1:0]        req_type,
   input  logic [2:0]        button_mask,
   input  logic [7:0]        temp_value,
   output acc_pkg::state_type state_in
);

   acc_pkg::state_type state_ff;

   // Years stay in 2000..2099, so the century rule never applies.
   function automatic logic [4:0] month_len(logic [3:0] m, logic [11:0] y);
      logic [4:0] len;
      case (m) inside
         4'd2:                                  len = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:               len = 5'd30;
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         default:                               len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic acc_pkg::state_type wrap_month(acc_pkg::state_type s);
      acc_pkg::state_type r;
      r = s;
      if (r.month_num >= acc_pkg::MonthWrap) begin
         r.month_num = 4'd1;
         r.year_num  = (r.year_num >= acc_pkg::YearLast) ? acc_pkg::YearFirst
                                                        : r.year_num + 12'd1;
      end
      return r;
   endfunction

   // Day plus one, carried into the month; compare before the add keeps it in 5 bits.
   function automatic acc_pkg::state_type advance_day(acc_pkg::state_type s);
      acc_pkg::state_type r;
      logic [4:0]         len;
      r   = s;
      len = month_len(r.month_num, r.year_num);
      if (len != 5'd0 && r.day_of_month >= len) begin
         r.day_of_month = 5'd1;
         r.month_num    = r.month_num + 4'd1;
      end else begin
         r.day_of_month = r.day_of_month + 5'd1;
      end
      return r;
   endfunction

   acc_pkg::state_type nx;
   logic [1:0]         phase;
   logic               midnight;

   always_comb begin
      nx       = state_ff;
      phase    = state_ff.alarm_phase;
      midnight = 1'b0;
      unique case (acc_pkg::req_kind_type'(req_type))
         acc_pkg::REQ_TICK: begin
            nx.seconds = nx.seconds + 6'd1;
            if (nx.seconds >= acc_pkg::SecPerMin) begin
               nx.seconds = 6'd0;
               nx.minutes = nx.minutes + 6'd1;
            end
            if (nx.minutes >= acc_pkg::SecPerMin) begin
               nx.minutes = 6'd0;
               nx.hours   = nx.hours + 4'd1;
            end
            if (nx.hours == acc_pkg::HourNoon && nx.minutes == 6'd0 && nx.seconds == 6'd0) begin
               midnight   = nx.pm_flag;
               nx.pm_flag = ~nx.pm_flag;
            end
            if (nx.hours >= acc_pkg::HourWrap) nx.hours = 4'd1;
            if (midnight) nx = advance_day(nx);
            nx = wrap_month(nx);
            // alarm pulse: armed at second 1, shown for exactly one tick
            if (nx.hours == nx.alarm_hour && nx.minutes == nx.alarm_minute &&
                nx.pm_flag == nx.alarm_pm && nx.seconds == 6'd1 && phase == 2'd0)
               phase = 2'd1;
            if (phase != 2'd0) phase = phase + 2'd1;
            if (phase == 2'd3) phase = 2'd0;
            nx.alarm_phase = phase;
         end
         acc_pkg::REQ_BUTTONS: begin
            if (button_mask[0])
               nx.display_mode = acc_pkg::mode_type'(2'(nx.display_mode) + 2'd1);
            if (button_mask[1]) begin
               unique case (nx.display_mode)
                  acc_pkg::MODE_TIME: begin
                     nx.hours   = nx.hours + 4'd1;
                     nx.seconds = 6'd0;
                     if (nx.hours == acc_pkg::HourNoon) nx.pm_flag = ~nx.pm_flag;
                     if (nx.hours >= acc_pkg::HourWrap) nx.hours = 4'd1;
                  end
                  acc_pkg::MODE_DATE: begin
                     nx.month_num    = nx.month_num + 4'd1;
                     nx.seconds      = 6'd0;
                     nx.day_of_month = 5'd1;
                     nx              = wrap_month(nx);
                  end
                  acc_pkg::MODE_ALARM: begin
                     nx.alarm_hour = nx.alarm_hour + 4'd1;
                     if (nx.alarm_hour == acc_pkg::HourNoon) nx.alarm_pm = ~nx.alarm_pm;
                     if (nx.alarm_hour >= acc_pkg::HourWrap) nx.alarm_hour = 4'd1;
                  end
                  default: ;
               endcase
            end
            if (button_mask[2]) begin
               unique case (nx.display_mode)
                  acc_pkg::MODE_TIME: begin
                     nx.minutes = nx.minutes + 6'd1;
                     nx.seconds = 6'd0;
                     if (nx.minutes > acc_pkg::MinuteMax) nx.minutes = 6'd0;
                  end
                  acc_pkg::MODE_DATE: begin
                     nx = advance_day(nx);
                     nx = wrap_month(nx);
                  end
                  acc_pkg::MODE_ALARM: begin
                     nx.alarm_minute = nx.alarm_minute + 6'd1;
                     if (nx.alarm_minute > acc_pkg::MinuteMax) nx.alarm_minute = 6'd0;
                  end
                  default: ;
               endcase
            end
         end
         acc_pkg::REQ_TEMP: nx.temperature = temp_value;
         default: ;
      endcase
   end

   assign state_in = nx;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= acc_pkg::StateReset;
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/acc_disp.sv =====
// Display formatter: picks the six digits and lamps for the current mode.
// Depends on acc_pkg.
`timescale 1ns / 1ps

module acc_disp (
   input  acc_pkg::state_type    st,
   output acc_pkg::rsp_data_type data
);

   // tens and units of a value below 100; *205 >> 11 equals /10 in that range
   function automatic logic [7:0] two_digits(logic [6:0] v);
      logic [14:0] p;
      logic [3:0]  tens;
      logic [6:0]  units;
      p     = 15'(v) * 15'd205;
      tens  = p[14:11];
      units = v - 7'(tens * 7'd10);
      return {tens, units[3:0]};
   endfunction

   logic [13:0] hund_p;
   logic [1:0]  hund;
   logic [6:0]  temp_rem;
   logic [6:0]  year_low;
   logic [7:0]  hh, mm, ss, mo, dd, yy, ah, am, tt;

   always_comb begin
      hund_p   = 14'(st.temperature) * 14'd41;   // /100 for values below 256
      hund     = hund_p[13:12];
      temp_rem = 7'(st.temperature - 8'(hund * 8'd100));
      year_low = 7'(st.year_num - acc_pkg::YearFirst);
      hh = two_digits(7'(st.hours));
      mm = two_digits(7'(st.minutes));
      ss = two_digits(7'(st.seconds));
      mo = two_digits(7'(st.month_num));
      dd = two_digits(7'(st.day_of_month));
      yy = two_digits(year_low);
      ah = two_digits(7'(st.alarm_hour));
      am = two_digits(7'(st.alarm_minute));
      tt = two_digits(temp_rem);

      unique case (st.display_mode)
         acc_pkg::MODE_TIME: begin
            {data.digit_0, data.digit_1} = hh;
            {data.digit_2, data.digit_3} = mm;
            {data.digit_4, data.digit_5} = ss;
         end
         acc_pkg::MODE_DATE: begin
            {data.digit_0, data.digit_1} = mo;
            {data.digit_2, data.digit_3} = dd;
            {data.digit_4, data.digit_5} = yy;
         end
         acc_pkg::MODE_ALARM: begin
            {data.digit_0, data.digit_1} = ah;
            {data.digit_2, data.digit_3} = am;
            {data.digit_4, data.digit_5} = 8'd0;
         end
         default: begin
            {data.digit_0, data.digit_1, data.digit_2} = 12'd0;
            data.digit_3                 = 4'(hund);
            {data.digit_4, data.digit_5} = tt;
         end
      endcase
      data.pm_lamp      = (st.display_mode == acc_pkg::MODE_ALARM) ? st.alarm_pm : st.pm_flag;
      data.alarm_active = (st.alarm_phase != 2'd0);
      data.mode_now     = 2'(st.display_mode);
   end

endmodule

// ===== rtl/core/alarm_clock_calendar.sv =====
// Top level of the twelve-hour clock calendar with alarm.
// Depends on acc_pkg, acc_req_if, acc_rsp_if, acc_core and acc_disp.
//
// Takes one item per clock cycle (a tick, a button mask or a temperature byte)
// and gives exactly one result per item. The item is captured in an input
// register at the accepting edge. The clock/calendar update and the digit
// formatting run in one pass, and the result is loaded into an output register
// once that register is free. The block keeps taking items while a result
// waits, and stalls only when both registers are full and the result side is
// not ready. Reset starts at 12:00:00 AM, January 1 2000, time mode, alarm
// 12:00 AM.
`timescale 1ns / 1ps

module alarm_clock_calendar (
   input  logic      clock,
   input  logic      reset,
   acc_req_if.sink   req_chan,
   acc_rsp_if.source rsp_chan
);

   logic       in_valid_ff;
   logic [1:0] in_type_ff;
   logic [2:0] in_mask_ff;
   logic [7:0] in_temp_ff;

   logic                  out_valid_ff;
   acc_pkg::rsp_data_type out_data_ff;
   acc_pkg::rsp_data_type out_data_in;

   acc_pkg::state_type state_in;
   logic               out_free;
   logic               step_en;

   assign out_free       = ~out_valid_ff | rsp_chan.ready;
   assign step_en        = in_valid_ff & out_free;
   assign req_chan.ready = ~in_valid_ff | out_free;

   acc_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_en),
      .req_type    (in_type_ff),
      .button_mask (in_mask_ff),
      .temp_value  (in_temp_ff),
      .state_in    (state_in)
   );

   acc_disp u_disp (
      .st   (state_in),
      .data (out_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) in_valid_ff <= req_chan.valid;
         if (out_free) out_valid_ff <= in_valid_ff;
      end
      if (req_chan.valid & req_chan.ready) begin
         in_type_ff <= req_chan.req_type;
         in_mask_ff <= req_chan.button_mask;
         in_temp_ff <= req_chan.temp_value;
      end
      if (step_en) out_data_ff <= out_data_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.digit_0      = out_data_ff.digit_0;
   assign rsp_chan.digit_1      = out_data_ff.digit_1;
   assign rsp_chan.digit_2      = out_data_ff.digit_2;
   assign rsp_chan.digit_3      = out_data_ff.digit_3;
   assign rsp_chan.digit_4      = out_data_ff.digit_4;
   assign rsp_chan.digit_5      = out_data_ff.digit_5;
   assign rsp_chan.pm_lamp      = out_data_ff.pm_lamp;
   assign rsp_chan.alarm_active = out_data_ff.alarm_active;
   assign rsp_chan.mode_now     = out_data_ff.mode_now;

endmodule

// ===== rtl/core/acc_chk.sv =====
// Port-level checks for alarm_clock_calendar, attached by bind.
// Depends on acc_pkg and the top level's channel interfaces.
`timescale 1ns / 1ps

module acc_chk (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] digit_0,
   input logic [3:0] digit_1,
   input logic [3:0] digit_2,
   input logic [3:0] digit_3,
   input logic [3:0] digit_4,
   input logic [3:0] digit_5,
   input logic [1:0] mode_now
);

   // no result may appear in the cycle right after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // an empty output side must never hold off the request side
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with no pending result");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (digit_0 <= 4'd9 && digit_1 <= 4'd9 && digit_2 <= 4'd9 &&
                     digit_3 <= 4'd9 && digit_4 <= 4'd9 && digit_5 <= 4'd9))
      else $error("display digit out of decimal range");

   // blank digit positions in alarm and temperature modes
   a_blank_digits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((mode_now != acc_pkg::MODE_ALARM ||
                      (digit_4 == 4'd0 && digit_5 == 4'd0)) &&
                     (mode_now != acc_pkg::MODE_TEMP ||
                      (digit_0 == 4'd0 && digit_1 == 4'd0 && digit_2 == 4'd0))))
      else $error("blank digit position not zero");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(mode_now) && $stable(digit_0))
      else $error("stalled result changed");

endmodule

bind alarm_clock_calendar acc_chk u_acc_chk (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .digit_0   (rsp_chan.digit_0),
   .digit_1   (rsp_chan.digit_1),
   .digit_2   (rsp_chan.digit_2),
   .digit_3   (rsp_chan.digit_3),
   .digit_4   (rsp_chan.digit_4),
   .digit_5   (rsp_chan.digit_5),
   .mode_now  (rsp_chan.mode_now)
);

// ===== sim/alarm_clock_calendar_test.sv =====
// Testbench for alarm_clock_calendar: directed and random ticks, button masks and
// temperature bytes, every display result checked against an in-bench clock model.
// Depends on acc_pkg, acc_req_if, acc_rsp_if and the alarm_clock_calendar RTL.
`timescale 1ns / 1ps

module alarm_clock_calendar_test;

   localparam logic [2:0] BtnMode   = 3'b001;
   localparam logic [2:0] BtnHour   = 3'b010;
   localparam logic [2:0] BtnMinute = 3'b100;
   localparam int RandomItems = 700;
   localparam int CycleLimit  = 200000;
   localparam int LongStall   = 80;

   typedef struct packed {
      acc_pkg::req_kind_type kind;
      logic [2:0]            buttons;
      logic [7:0]            temp;
   } clock_item_type;

   logic clock;
   logic reset;

   acc_req_if req_chan ();
   acc_rsp_if rsp_chan ();

   alarm_clock_calendar DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   clock_item_type        pending_items[$];
   acc_pkg::rsp_data_type expected_displays[$];
   acc_pkg::state_type    queued_clock;    // clock as of the last queued item, steers stimulus
   acc_pkg::state_type    accepted_clock;  // clock as of the last accepted item
   int error_count;
   int sent_count;
   int shown_count;
   int send_gap;
   int hold_left;
   int cycle_count;

   function automatic acc_pkg::state_type reset_clock();
      acc_pkg::state_type s;
      s.seconds      = 6'd0;
      s.minutes      = 6'd0;
      s.hours        = 4'd12;
      s.pm_flag      = 1'b0;
      s.day_of_month = 5'd1;
      s.month_num    = 4'd1;
      s.year_num     = 12'd2000;
      s.display_mode = acc_pkg::MODE_TIME;
      s.alarm_hour   = 4'd12;
      s.alarm_minute = 6'd0;
      s.alarm_pm     = 1'b0;
      s.alarm_phase  = 2'd0;
      s.temperature  = 8'd69;
      return s;
   endfunction

   function automatic acc_pkg::state_type wrap_month(acc_pkg::state_type s);
      if (s.month_num >= acc_pkg::MonthWrap) begin
         s.month_num = 4'd1;
         s.year_num  = (s.year_num >= acc_pkg::YearLast) ? acc_pkg::YearFirst
                                                         : s.year_num + 12'd1;
      end
      return s;
   endfunction

   // day can run one past the 5-bit field, so it comes in as an int
   function automatic acc_pkg::state_type settle_date(acc_pkg::state_type s, int day);
      int month_len;
      bit leap;
      leap = (s.year_num % 4 == 0) && ((s.year_num % 100 != 0) || (s.year_num % 400 == 0));
      case (s.month_num)
         4'd2:                                      month_len = leap ? 29 : 28;
         4'd4, 4'd6, 4'd9, 4'd11:                   month_len = 30;
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 31;
         default:                                   month_len = 0;
      endcase
      if (month_len != 0 && day > month_len) begin
         day = 1;
         s.month_num = s.month_num + 4'd1;
      end
      s.day_of_month = 5'(day);
      return wrap_month(s);
   endfunction

   function automatic acc_pkg::state_type advance_clock(acc_pkg::state_type s,
                                                        clock_item_type it);
      int sec;
      int min;
      int hr;
      int day;
      case (it.kind)
         acc_pkg::REQ_TICK: begin
            sec = int'(s.seconds) + 1;
            min = int'(s.minutes);
            hr  = int'(s.hours);
            day = int'(s.day_of_month);
            if (sec >= acc_pkg::SecPerMin) begin
               sec = 0;
               min++;
            end
            if (min >= acc_pkg::SecPerMin) begin
               min = 0;
               hr++;
            end
            // noon turns PM on, midnight turns it off and moves the date
            if (hr == acc_pkg::HourNoon && min == 0 && sec == 0) begin
               if (s.pm_flag) begin
                  day++;
                  s.pm_flag = 1'b0;
               end else begin
                  s.pm_flag = 1'b1;
               end
            end
            if (hr >= acc_pkg::HourWrap) hr = 1;
            s.seconds = 6'(sec);
            s.minutes = 6'(min);
            s.hours   = 4'(hr);
            s = settle_date(s, day);
            if (s.hours == s.alarm_hour && s.minutes == s.alarm_minute &&
                s.pm_flag == s.alarm_pm && s.seconds == 6'd1 && s.alarm_phase == 2'd0)
               s.alarm_phase = 2'd1;
            // pulse lasts one tick: 1 -> 2 now, 2 -> 3 -> 0 on the next tick
            if (s.alarm_phase != 2'd0) s.alarm_phase = s.alarm_phase + 2'd1;
            if (s.alarm_phase == 2'd3) s.alarm_phase = 2'd0;
         end
         acc_pkg::REQ_BUTTONS: begin
            if (it.buttons & BtnMode)
               s.display_mode = acc_pkg::mode_type'(s.display_mode + 2'd1);
            if (it.buttons & BtnHour) begin
               case (s.display_mode)
                  acc_pkg::MODE_TIME: begin
                     hr = int'(s.hours) + 1;
                     s.seconds = 6'd0;
                     if (hr == acc_pkg::HourNoon) s.pm_flag = ~s.pm_flag;
                     if (hr >= acc_pkg::HourWrap) hr = 1;
                     s.hours = 4'(hr);
                  end
                  acc_pkg::MODE_DATE: begin
                     s.month_num    = s.month_num + 4'd1;
                     s.seconds      = 6'd0;
                     s.day_of_month = 5'd1;
                     s = wrap_month(s);
                  end
                  acc_pkg::MODE_ALARM: begin
                     hr = int'(s.alarm_hour) + 1;
                     if (hr == acc_pkg::HourNoon) s.alarm_pm = ~s.alarm_pm;
                     if (hr >= acc_pkg::HourWrap) hr = 1;
                     s.alarm_hour = 4'(hr);
                  end
                  default: ;
               endcase
            end
            if (it.buttons & BtnMinute) begin
               case (s.display_mode)
                  acc_pkg::MODE_TIME: begin
                     s.minutes = (s.minutes >= acc_pkg::MinuteMax) ? 6'd0 : s.minutes + 6'd1;
                     s.seconds = 6'd0;
                  end
                  acc_pkg::MODE_DATE: s = settle_date(s, int'(s.day_of_month) + 1);
                  acc_pkg::MODE_ALARM: begin
                     s.alarm_minute = (s.alarm_minute >= acc_pkg::MinuteMax)
                                      ? 6'd0 : s.alarm_minute + 6'd1;
                  end
                  default: ;
               endcase
            end
         end
         acc_pkg::REQ_TEMP: s.temperature = it.temp;
         default: ;
      endcase
      return s;
   endfunction

   function automatic logic [7:0] two_digits(int v);
      return {4'((v / 10) % 10), 4'(v % 10)};
   endfunction

   function automatic acc_pkg::rsp_data_type show_clock(acc_pkg::state_type s);
      acc_pkg::rsp_data_type d;
      case (s.display_mode)
         acc_pkg::MODE_TIME: begin
            {d.digit_0, d.digit_1, d.digit_2, d.digit_3, d.digit_4, d.digit_5} =
               {two_digits(int'(s.hours)), two_digits(int'(s.minutes)),
                two_digits(int'(s.seconds))};
         end
         acc_pkg::MODE_DATE: begin
            {d.digit_0, d.digit_1, d.digit_2, d.digit_3, d.digit_4, d.digit_5} =
               {two_digits(int'(s.month_num)), two_digits(int'(s.day_of_month)),
                two_digits(int'(s.year_num))};
         end
         acc_pkg::MODE_ALARM: begin
            {d.digit_0, d.digit_1, d.digit_2, d.digit_3, d.digit_4, d.digit_5} =
               {two_digits(int'(s.alarm_hour)), two_digits(int'(s.alarm_minute)), 8'h00};
         end
         default: begin
            {d.digit_0, d.digit_1, d.digit_2, d.digit_3, d.digit_4, d.digit_5} =
               {12'h000, 4'((int'(s.temperature) / 100) % 10),
                two_digits(int'(s.temperature))};
         end
      endcase
      d.pm_lamp      = (s.display_mode == acc_pkg::MODE_ALARM) ? s.alarm_pm : s.pm_flag;
      d.alarm_active = (s.alarm_phase != 2'd0);
      d.mode_now     = 2'(s.display_mode);
      return d;
   endfunction

   task automatic queue_item(acc_pkg::req_kind_type kind, logic [2:0] buttons,
                             logic [7:0] temp);
      clock_item_type it;
      it.kind    = kind;
      it.buttons = buttons;
      it.temp    = temp;
      pending_items.push_back(it);
      queued_clock = advance_clock(queued_clock, it);
   endtask

   task automatic queue_tick();
      queue_item(acc_pkg::REQ_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
   endtask

   task automatic queue_press(logic [2:0] mask);
      queue_item(acc_pkg::REQ_BUTTONS, mask, 8'($urandom_range(0, 255)));
   endtask

   task automatic steer_mode(acc_pkg::mode_type m);
      while (queued_clock.display_mode != m) queue_press(BtnMode);
   endtask

   task automatic check_field(string name, logic [11:0] want, logic [11:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   // driver: one pending item at a time, random gap after each accepted item but in back-to-back runs
   always @(posedge clock) begin
      clock_item_type it;
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            it.kind    = acc_pkg::req_kind_type'(req_chan.req_type);
            it.buttons = req_chan.button_mask;
            it.temp    = req_chan.temp_value;
            accepted_clock = advance_clock(accepted_clock, it);
            expected_displays.push_back(show_clock(accepted_clock));
            sent_count++;
            send_gap = (sent_count % 80 >= 56) ? 0 : $urandom_range(0, 6);
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               it = pending_items.pop_front();
               req_chan.valid       <= 1'b1;
               req_chan.req_type    <= it.kind;
               req_chan.button_mask <= it.buttons;
               req_chan.temp_value  <= it.temp;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each result item, random hold-off after each one but in back-to-back runs
   always @(posedge clock) begin
      acc_pkg::rsp_data_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_displays.size() == 0) begin
               $error("result item with no request item outstanding");
               error_count++;
            end else begin
               want = expected_displays.pop_front();
               check_field("digit_0", 12'(want.digit_0), 12'(rsp_chan.digit_0));
               check_field("digit_1", 12'(want.digit_1), 12'(rsp_chan.digit_1));
               check_field("digit_2", 12'(want.digit_2), 12'(rsp_chan.digit_2));
               check_field("digit_3", 12'(want.digit_3), 12'(rsp_chan.digit_3));
               check_field("digit_4", 12'(want.digit_4), 12'(rsp_chan.digit_4));
               check_field("digit_5", 12'(want.digit_5), 12'(rsp_chan.digit_5));
               check_field("pm_lamp", 12'(want.pm_lamp), 12'(rsp_chan.pm_lamp));
               check_field("alarm_active", 12'(want.alarm_active),
                           12'(rsp_chan.alarm_active));
               check_field("mode_now", 12'(want.mode_now), 12'(rsp_chan.mode_now));
            end
            shown_count++;
            hold_left = (shown_count % 96 >= 64) ? 0 : $urandom_range(0, 6);
            // one long back-pressure stretch so the block fills and stalls its input
            if (shown_count == 200) hold_left = LongStall;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      int base;
      int target;
      int n;
      logic pm;
      logic [7:0] t;

      reset          = 1'b1;
      error_count    = 0;
      queued_clock   = reset_clock();
      accepted_clock = reset_clock();

      queue_tick();
      queue_item(acc_pkg::REQ_NONE, 3'b111, 8'hFF);
      queue_item(acc_pkg::REQ_TEMP, 3'b000, 8'd0);
      queue_item(acc_pkg::REQ_TEMP, 3'b111, 8'd255);
      queue_press(3'b000);
      queue_press(BtnHour);                         // 12 wraps to 1, no PM change
      queue_press(BtnMinute);
      queue_press(BtnMode | BtnHour | BtnMinute);   // into date mode, then month, then day
      queue_press(BtnMinute);
      queue_press(BtnMode);                         // alarm mode, lamp shows alarm PM
      queue_press(BtnHour | BtnMinute);
      queue_press(BtnMode);                         // temperature mode
      queue_press(BtnHour | BtnMinute);             // no effect here
      queue_item(acc_pkg::REQ_TEMP, 3'b000, 8'd100);
      queue_item(acc_pkg::REQ_TEMP, 3'b000, 8'd99);
      queue_tick();
      queue_press(BtnMode);
      queue_item(acc_pkg::REQ_TICK, 3'b111, 8'hFF);
      queue_item(acc_pkg::REQ_NONE, 3'b000, 8'd0);
      queue_press(BtnMode | BtnHour);

      base = pending_items.size();
      while (pending_items.size() < base + RandomItems) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               repeat ($urandom_range(4, 12))
                  queue_item(acc_pkg::req_kind_type'($urandom_range(0, 3)),
                             3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            end
            2, 3: begin
               // run the time up to or across an hour boundary, often noon or midnight
               if ($urandom_range(0, 1)) begin
                  steer_mode(acc_pkg::MODE_DATE);
                  target = 28 + $urandom_range(0, 3);
                  n = 0;
                  while (queued_clock.day_of_month < target && n < 40) begin
                     queue_press(BtnMinute);
                     n++;
                  end
               end
               steer_mode(acc_pkg::MODE_TIME);
               target = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 11;
               pm = ($urandom_range(0, 2) != 0);
               while (!(queued_clock.hours == target && queued_clock.pm_flag == pm))
                  queue_press(BtnHour);
               target = 58 + $urandom_range(0, 1);
               while (queued_clock.minutes != target) queue_press(BtnMinute);
               if ($urandom_range(0, 1))
                  steer_mode(acc_pkg::mode_type'($urandom_range(0, 3)));
               repeat ($urandom_range(60, 130)) queue_tick();
            end
            4, 5: begin
               // set the alarm to the current minute so the next tick fires it
               steer_mode(acc_pkg::MODE_TIME);
               queue_press(BtnMinute);
               steer_mode(acc_pkg::MODE_ALARM);
               while (!(queued_clock.alarm_hour == queued_clock.hours &&
                        queued_clock.alarm_pm == queued_clock.pm_flag))
                  queue_press(BtnHour);
               while (queued_clock.alarm_minute != queued_clock.minutes)
                  queue_press(BtnMinute);
               if ($urandom_range(0, 1))
                  steer_mode(acc_pkg::mode_type'($urandom_range(0, 3)));
               repeat ($urandom_range(1, 4)) begin
                  queue_tick();
                  if ($urandom_range(0, 1))
                     queue_item(acc_pkg::REQ_TEMP, 3'($urandom_range(0, 7)),
                                8'($urandom_range(0, 255)));
                  // month step clears seconds: match again while the pulse still runs
                  if ($urandom_range(0, 3) == 0) begin
                     steer_mode(acc_pkg::MODE_DATE);
                     queue_press(BtnHour);
                  end
               end
            end
            6, 7: begin
               steer_mode(acc_pkg::MODE_DATE);
               n = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 30) : $urandom_range(0, 13);
               repeat (n) queue_press($urandom_range(0, 1) ? BtnHour : (BtnHour | BtnMinute));
               repeat ($urandom_range(25, 35)) queue_press(BtnMinute);
            end
            8: begin
               steer_mode(acc_pkg::MODE_TEMP);
               repeat ($urandom_range(4, 12)) begin
                  case ($urandom_range(0, 9))
                     0:       t = 8'd0;
                     1:       t = 8'd9;
                     2:       t = 8'd100;
                     3:       t = 8'd255;
                     default: t = 8'($urandom_range(0, 255));
                  endcase
                  queue_item(acc_pkg::REQ_TEMP, 3'($urandom_range(0, 7)), t);
                  if ($urandom_range(0, 2) == 0) queue_press(BtnHour | BtnMinute);
                  if ($urandom_range(0, 2) == 0) queue_tick();
               end
            end
            default: begin
               repeat ($urandom_range(5, 15)) queue_press(3'($urandom_range(0, 7)));
            end
         endcase
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() > 0 || req_chan.valid || expected_displays.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
